// ===== hw/rtl/scw_pkg.sv =====
// Shared types and constants for the stuck capture line watchdog.
`default_nettype none
package scw_pkg;

   localparam int unsigned SpanWidth = 16;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 56;
   localparam int unsigned RspDataWidth = 40;

   localparam logic [SpanWidth-1:0] FlatSpanReset = 16'd2;
   localparam logic [TimeWidth-1:0] HoldMsReset = 32'd2000;
   localparam logic [TimeWidth-1:0] RetryMsReset = 32'd30000;

   typedef enum logic [1:0] {
      CMD_SAMPLE   = 2'd0,
      CMD_MAINTAIN = 2'd1,
      CMD_RECOVER  = 2'd2
   } cmd_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_FLAT_SPAN = 2'd0,
      CSR_HOLD_MS   = 2'd1,
      CSR_RETRY_MS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SpanWidth-1:0] flat_span;
      logic [TimeWidth-1:0] hold_ms;
      logic [TimeWidth-1:0] retry_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic [TimeWidth-1:0]        now_ms;
      logic signed [SpanWidth-1:0] sample;
      logic                        last_of_buffer;
      logic                        codec_present;
      logic                        busy_req;
      logic                        recover_ok;
   } item_type;

   typedef struct packed {
      logic                 line_dead;
      logic                 recover_request;
      logic [TimeWidth-1:0] recovery_count;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/scw_core.sv =====
// Watchdog state and the per-transfer decision logic.
`default_nettype none
module scw_core
   import scw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic signed [SpanWidth-1:0] span_low_ff, span_low_in;
   logic signed [SpanWidth-1:0] span_high_ff, span_high_in;
   logic                        mid_buffer_ff, mid_buffer_in;
   logic [TimeWidth-1:0]        dead_start_ff, dead_start_in;
   logic [TimeWidth-1:0]        last_attempt_ff, last_attempt_in;
   logic [TimeWidth-1:0]        rebuild_total_ff, rebuild_total_in;

   logic [TimeWidth-1:0] stamp;
   logic [TimeWidth-1:0] dead_age;
   logic [TimeWidth-1:0] retry_age;
   logic                 dead_now;
   logic                 stamp_dead;
   logic                 due;
   logic [SpanWidth:0]   span;
   logic                 span_dead;

   always_comb begin
      stamp = (item.now_ms == '0) ? {{(TimeWidth-1){1'b0}}, 1'b1} : item.now_ms;
      dead_age = item.now_ms - dead_start_ff;
      retry_age = item.now_ms - last_attempt_ff;
      dead_now = (dead_start_ff != '0) && (dead_age >= cfg.hold_ms);
      // fresh stamp: age is 0, or all ones when now wrapped to zero
      stamp_dead = (item.now_ms == '0) || (cfg.hold_ms == '0);
      due = (last_attempt_ff == '0) || (retry_age >= cfg.retry_ms);

      if (!mid_buffer_ff) begin
         span_low_in = item.sample;
         span_high_in = item.sample;
      end else begin
         span_low_in = (item.sample < span_low_ff) ? item.sample : span_low_ff;
         span_high_in = (item.sample > span_high_ff) ? item.sample : span_high_ff;
      end
      span = {span_high_in[SpanWidth-1], span_high_in}
           - {span_low_in[SpanWidth-1], span_low_in};
      span_dead = span <= {1'b0, cfg.flat_span};

      mid_buffer_in = mid_buffer_ff;
      dead_start_in = dead_start_ff;
      last_attempt_in = last_attempt_ff;
      rebuild_total_in = rebuild_total_ff;
      result.line_dead = dead_now;
      result.recover_request = 1'b0;

      unique case (item.cmd)
         CMD_SAMPLE: begin
            if (item.last_of_buffer) begin
               mid_buffer_in = 1'b0;
               if (span_dead) begin
                  if (dead_start_ff == '0) begin
                     dead_start_in = stamp;
                     result.line_dead = stamp_dead;
                  end
               end else begin
                  dead_start_in = '0;
                  result.line_dead = 1'b0;
               end
            end else begin
               mid_buffer_in = 1'b1;
            end
         end
         CMD_MAINTAIN: begin
            if (!item.busy_req && due && (!item.codec_present || dead_now)) begin
               last_attempt_in = stamp;
               result.recover_request = 1'b1;
            end
         end
         CMD_RECOVER: begin
            dead_start_in = '0;
            result.line_dead = 1'b0;
            if (item.recover_ok) begin
               rebuild_total_in = rebuild_total_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      result.recovery_count = rebuild_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_low_ff <= '0;
         span_high_ff <= '0;
         mid_buffer_ff <= 1'b0;
         dead_start_ff <= '0;
         last_attempt_ff <= '0;
         rebuild_total_ff <= '0;
      end else if (advance) begin
         if (item.cmd == CMD_SAMPLE) begin
            span_low_ff <= span_low_in;
            span_high_ff <= span_high_in;
         end
         mid_buffer_ff <= mid_buffer_in;
         dead_start_ff <= dead_start_in;
         last_attempt_ff <= last_attempt_in;
         rebuild_total_ff <= rebuild_total_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/stuck_capture_line_watchdog.sv =====
// An accepted req transfer reaches its rsp transfer via the input reg, then the result reg.
// Throughput: one item per cycle unless the rsp side stalls; the core logic is single pass.
// req_tready drops only while the input register holds an item and the result register stalls.
// Reset (synchronous, active high) clears pipeline valids, watchdog state and loads
// register defaults: flat_span 2, hold_ms 2000, retry_ms 30000.
`default_nettype none
module stuck_capture_line_watchdog
   import scw_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // now_ms[31:0], sample[47:32], codec_present[48], busy_req[49], recover_ok[50], zero pad
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]              req_tuser,
   input  wire logic                    req_tlast,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // line_dead[0], recover_request[1], recovery_count[33:2], zero pad
   output logic [RspDataWidth-1:0]      rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic [CsrAddrWidth-1:0] csr_addr,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_ff, core_result;
   logic       out_valid_ff, out_valid_in;
   logic       req_fire;
   logic       advance;

   always_comb begin
      item_in.cmd = cmd_type'(req_tuser);
      item_in.now_ms = req_tdata[31:0];
      item_in.sample = req_tdata[47:32];
      item_in.codec_present = req_tdata[48];
      item_in.busy_req = req_tdata[49];
      item_in.recover_ok = req_tdata[50];
      item_in.last_of_buffer = req_tlast;

      advance = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_fire = req_tvalid && req_tready;
      in_valid_in = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);

      rsp_tvalid = out_valid_ff;
      rsp_tdata = {{(RspDataWidth-TimeWidth-2){1'b0}}, out_ff.recovery_count,
                   out_ff.recover_request, out_ff.line_dead};
   end

   scw_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ff <= '0;
         cfg_ff.flat_span <= FlatSpanReset;
         cfg_ff.hold_ms <= HoldMsReset;
         cfg_ff.retry_ms <= RetryMsReset;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            out_ff <= core_result;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_FLAT_SPAN: cfg_ff.flat_span <= csr_wdata[SpanWidth-1:0];
               CSR_HOLD_MS:   cfg_ff.hold_ms <= csr_wdata[TimeWidth-1:0];
               CSR_RETRY_MS:  cfg_ff.retry_ms <= csr_wdata[TimeWidth-1:0];
               default: begin
               end
            endcase
         end
      end
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

`ifndef ASSERT_OFF
   // a held input item is never dropped while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input item lost while stalled");

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("req_tready low without a full stalled pipeline");

   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_ff))
      else $error("result register changed without a new item");

   a_request_is_maintain: assert property (@(posedge clock) disable iff (reset)
      advance && core_result.recover_request |-> item_ff.cmd == CMD_MAINTAIN)
      else $error("rebuild request on a non-maintain item");
`endif

endmodule
`default_nettype wire
